### rtl/abqd_pkg.sv
`timescale 1ns / 1ps

package abqd_pkg;

  // Field widths of the transaction ports
  localparam int REQ_W      = 2;
  localparam int ADDR_W     = 48;
  localparam int LEN_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int COPY_W     = 17;
  localparam int START_W    = 17;
  localparam int END_W      = 18;
  localparam int OUTST_W    = 5;
  localparam int PLAY_W     = 32;

  // Configuration registers
  localparam int LIMIT_W    = 5;
  localparam int CHAN_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'd1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
  localparam logic [CHAN_W-1:0]  CHAN_RESET  = 2'd2;

  // Playback slots and ring geometry
  localparam int SLOT_COUNT  = 4;
  localparam int SLOT_W      = 2;
  localparam int SLOT_CNT_W  = 3;
  localparam int BLOCK_BYTES = 65536;
  localparam int BLOCK_LOG2  = 16;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ENQUEUE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd2;

  // Enqueue status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
  } desc_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } fifo_ctrl_t;

  typedef struct packed {
    logic step;
    logic tick;
    logic clear;
    logic want;
  } sched_ctrl_t;

  typedef struct packed {
    logic              completed;
    logic              dispatched;
    logic [SLOT_W-1:0] idx;
  } sched_stat_t;

endpackage

### rtl/abqd_fifo.sv
`timescale 1ns / 1ps

module abqd_fifo #(
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  abqd_pkg::fifo_ctrl_t                   ctrl_i,
  input  abqd_pkg::desc_t                        wdata_i,
  output abqd_pkg::desc_t                        head_o,
  output logic [$clog2(DEPTH+1)-1:0]             count_o
);
  import abqd_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  desc_t         mem [DEPTH];
  desc_t         head_q;
  logic [PW-1:0] rp_q, rp_d, wp_q, wp_d;
  logic [CW-1:0] count_q, count_d;

  // Advance pointers and occupancy
  always_comb begin
    rp_d    = rp_q;
    wp_d    = wp_q;
    count_d = count_q;
    if (ctrl_i.clear) begin
      rp_d    = '0;
      wp_d    = '0;
      count_d = '0;
    end else if (ctrl_i.push) begin
      wp_d    = (wp_q == LAST) ? '0 : wp_q + 1'b1;
      count_d = count_q + 1'b1;
    end else if (ctrl_i.pop) begin
      rp_d    = (rp_q == LAST) ? '0 : rp_q + 1'b1;
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q    <= '0;
      wp_q    <= '0;
      count_q <= '0;
    end else begin
      rp_q    <= rp_d;
      wp_q    <= wp_d;
      count_q <= count_d;
    end
  end

  // Write the descriptor store; prefetch the next head, forward a write to it
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[wp_q] <= wdata_i;
    end
    if (ctrl_i.push && (wp_q == rp_d)) begin
      head_q <= wdata_i;
    end else begin
      head_q <= mem[rp_d];
    end
  end

  assign head_o  = head_q;
  assign count_o = count_q;

endmodule

### rtl/abqd_slot_sched.sv
`timescale 1ns / 1ps

module abqd_slot_sched (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  abqd_pkg::sched_ctrl_t                 ctrl_i,
  input  logic [abqd_pkg::SLOT_COUNT-1:0]       done_i,
  output abqd_pkg::sched_stat_t                 stat_o,
  output logic [abqd_pkg::SLOT_CNT_W-1:0]       pend_cnt_o,
  output logic [abqd_pkg::SLOT_CNT_W-1:0]       pend_cnt_next_o
);
  import abqd_pkg::*;

  logic [SLOT_COUNT-1:0] pend_q, pend_d, pend_mid, ret_oh;
  logic [SLOT_W-1:0]     next_q, next_d, idx, cand;
  logic                  ret_hit, found, dispatched;
  logic [SLOT_CNT_W-1:0] cnt_q, cnt_d;

  // Retire the lowest pending slot that is marked done
  always_comb begin
    ret_hit = 1'b0;
    ret_oh  = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!ret_hit && pend_q[i] && done_i[i]) begin
        ret_hit   = 1'b1;
        ret_oh[i] = 1'b1;
      end
    end
    pend_mid = ctrl_i.tick ? (pend_q & ~ret_oh) : pend_q;
  end

  // Search round robin for a free slot, starting at next_q
  always_comb begin
    found = 1'b0;
    idx   = '0;
    cand  = '0;
    for (int k = 0; k < SLOT_COUNT; k++) begin
      cand = next_q + SLOT_W'(k);
      if (!found && !pend_mid[cand]) begin
        found = 1'b1;
        idx   = cand;
      end
    end
  end

  assign dispatched = ctrl_i.tick && ctrl_i.want && found;

  // Mark the chosen slot busy, drop all on clear
  always_comb begin
    pend_d = pend_mid;
    next_d = next_q;
    if (ctrl_i.clear) begin
      pend_d = '0;
    end else if (dispatched) begin
      pend_d[idx] = 1'b1;
      next_d      = idx + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      next_q <= '0;
    end else if (ctrl_i.step) begin
      pend_q <= pend_d;
      next_q <= next_d;
    end
  end

  // Count busy slots before and after this transaction
  always_comb begin
    cnt_q = '0;
    cnt_d = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      cnt_q = cnt_q + SLOT_CNT_W'(pend_q[i]);
      cnt_d = cnt_d + SLOT_CNT_W'(pend_d[i]);
    end
  end

  assign stat_o.completed  = ctrl_i.tick && ret_hit;
  assign stat_o.dispatched = dispatched;
  assign stat_o.idx        = idx;
  assign pend_cnt_o        = cnt_q;
  assign pend_cnt_next_o   = cnt_d;

endmodule

### rtl/audio_buffer_queue_dispatcher.sv
`timescale 1ns / 1ps

// Channel   Handshake                   Payload
// -------   -------------------------   -----------------------------------------
// in        in_valid_i / in_stall_o     req_type_i .. downstream_accepts_i
// out       out_valid_o / out_stall_i   status_o .. play_index_o
// cfg       cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// One transaction per cycle sustained unless out_stall_i holds the result. A transaction is
// captured in the input register when accepted; the queue/slot update then writes the result
// register as the input register advances, and out_valid_o rises with that write.
// The descriptor store prefetches its head into a register, so a dispatch need not wait for it.
// rst_ni clears pointers, slots and counters and loads the configuration defaults at once; no clearing pass.
// out_stall_i holds the result register and back-pressures the input register.

module audio_buffer_queue_dispatcher #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [abqd_pkg::REQ_W-1:0]          req_type_i,
  input  logic [abqd_pkg::ADDR_W-1:0]         buffer_address_i,
  input  logic [abqd_pkg::LEN_W-1:0]          buffer_length_i,
  input  logic                                playing_i,
  input  logic [abqd_pkg::SLOT_COUNT-1:0]     slot_done_mask_i,
  input  logic                                downstream_accepts_i,

  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [abqd_pkg::STATUS_W-1:0]       status_o,
  output logic                                completed_o,
  output logic                                dispatched_o,
  output logic [abqd_pkg::SLOT_W-1:0]         slot_index_o,
  output logic [abqd_pkg::ADDR_W-1:0]         source_address_o,
  output logic [abqd_pkg::COPY_W-1:0]         copy_bytes_o,
  output logic [abqd_pkg::START_W-1:0]        start_sample_o,
  output logic [abqd_pkg::END_W-1:0]          end_sample_o,
  output logic [abqd_pkg::OUTST_W-1:0]        outstanding_count_o,
  output logic [abqd_pkg::PLAY_W-1:0]         play_index_o,

  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [abqd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [abqd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import abqd_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = $clog2(QUEUE_DEPTH + SLOT_COUNT + 32);

  // Configuration
  logic [LIMIT_W-1:0] limit_q;
  logic [CHAN_W-1:0]  chan_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
      chan_q  <= CHAN_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_QUEUE_LIMIT:   limit_q <= cfg_data_i;
        CFG_CHANNEL_COUNT: chan_q  <= cfg_data_i[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic                  s1_valid_q, s1_go, in_acc;
  logic [REQ_W-1:0]      req_q;
  logic [ADDR_W-1:0]     addr_q;
  logic [LEN_W-1:0]      len_q;
  logic                  playing_q, accepts_q;
  logic [SLOT_COUNT-1:0] done_q;
  logic                  out_valid_q;

  assign s1_go      = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q     <= req_type_i;
      addr_q    <= buffer_address_i;
      len_q     <= buffer_length_i;
      playing_q <= playing_i;
      done_q    <= slot_done_mask_i;
      accepts_q <= downstream_accepts_i;
    end
  end

  // Decode the request
  logic is_enq, is_tick, is_clr;

  always_comb begin
    is_enq  = 1'b0;
    is_tick = 1'b0;
    is_clr  = 1'b0;
    case (req_q)
      REQ_ENQUEUE: is_enq  = 1'b1;
      REQ_TICK:    is_tick = 1'b1;
      REQ_CLEAR:   is_clr  = 1'b1;
      default: ;
    endcase
  end

  // Descriptor queue and slot scheduler
  fifo_ctrl_t            fifo_ctrl;
  desc_t                 head, wdesc;
  logic [CW-1:0]         q_count;
  sched_ctrl_t           sch_ctrl;
  sched_stat_t           sch_stat;
  logic [SLOT_CNT_W-1:0] pend_cnt, pend_cnt_next;

  logic              invalid, full, push, pop;
  logic [TW-1:0]     lim_ext, lim_eff, occ, q_next;
  logic [STATUS_W-1:0] status_d;

  assign invalid = (addr_q == '0) || (len_q == '0);
  assign lim_ext = TW'(limit_q);
  assign lim_eff = (lim_ext > TW'(QUEUE_DEPTH)) ? TW'(QUEUE_DEPTH) : lim_ext;
  assign occ     = TW'(q_count) + TW'(pend_cnt);
  assign full    = occ >= lim_eff;
  assign push    = s1_go && is_enq && !invalid && !full;
  assign pop     = s1_go && sch_stat.dispatched;

  assign status_d = !is_enq ? ST_OK : (invalid ? ST_INVALID : (full ? ST_FULL : ST_OK));

  assign wdesc.addr      = addr_q;
  assign wdesc.len       = len_q;
  assign fifo_ctrl.push  = push;
  assign fifo_ctrl.pop   = pop;
  assign fifo_ctrl.clear = s1_go && is_clr;

  assign sch_ctrl.step  = s1_go;
  assign sch_ctrl.tick  = is_tick;
  assign sch_ctrl.clear = is_clr;
  assign sch_ctrl.want  = playing_q && (q_count != '0) && accepts_q;

  abqd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (fifo_ctrl),
    .wdata_i (wdesc),
    .head_o  (head),
    .count_o (q_count)
  );

  abqd_slot_sched u_sched (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (sch_ctrl),
    .done_i          (done_q),
    .stat_o          (sch_stat),
    .pend_cnt_o      (pend_cnt),
    .pend_cnt_next_o (pend_cnt_next)
  );

  // Clamp to the block, trim to whole frames, place in the ring
  logic               four;
  logic [COPY_W-1:0]  clamped, copy, frames;
  logic [START_W-1:0] start;
  logic [END_W-1:0]   stop;

  assign four    = (chan_q == 2'd2) || (chan_q == 2'd3);
  assign clamped = (head.len > LEN_W'(BLOCK_BYTES)) ? COPY_W'(BLOCK_BYTES) : COPY_W'(head.len);
  assign copy    = four ? {clamped[COPY_W-1:2], 2'b00} : {clamped[COPY_W-1:1], 1'b0};
  assign frames  = four ? (copy >> 2) : (copy >> 1);
  assign start   = four ? (START_W'(sch_stat.idx) << (BLOCK_LOG2 - 2))
                        : (START_W'(sch_stat.idx) << (BLOCK_LOG2 - 1));
  assign stop    = END_W'(start) + END_W'(frames);

  // Occupancy after this transaction
  always_comb begin
    if (is_clr) begin
      q_next = '0;
    end else if (is_enq && !invalid && !full) begin
      q_next = TW'(q_count) + 1'b1;
    end else if (sch_stat.dispatched) begin
      q_next = TW'(q_count) - 1'b1;
    end else begin
      q_next = TW'(q_count);
    end
  end

  // Retired buffer count
  logic [PLAY_W-1:0] retired_q, retired_d;

  assign retired_d = sch_stat.completed ? retired_q + 1'b1 : retired_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retired_q <= '0;
    end else if (s1_go) begin
      retired_q <= retired_d;
    end
  end

  // Result register
  logic [STATUS_W-1:0] status_q;
  logic                completed_q, dispatched_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [ADDR_W-1:0]   src_q;
  logic [COPY_W-1:0]   copy_q;
  logic [START_W-1:0]  start_q;
  logic [END_W-1:0]    end_q;
  logic [OUTST_W-1:0]  outst_q;
  logic [PLAY_W-1:0]   play_q;

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      status_q     <= status_d;
      completed_q  <= sch_stat.completed;
      dispatched_q <= sch_stat.dispatched;
      slot_q       <= sch_stat.dispatched ? sch_stat.idx : '0;
      src_q        <= sch_stat.dispatched ? head.addr : '0;
      copy_q       <= sch_stat.dispatched ? copy : '0;
      start_q      <= sch_stat.dispatched ? start : '0;
      end_q        <= sch_stat.dispatched ? stop : '0;
      outst_q      <= OUTST_W'(q_next + TW'(pend_cnt_next));
      play_q       <= retired_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign completed_o         = completed_q;
  assign dispatched_o        = dispatched_q;
  assign slot_index_o        = slot_q;
  assign source_address_o    = src_q;
  assign copy_bytes_o        = copy_q;
  assign start_sample_o      = start_q;
  assign end_sample_o        = end_q;
  assign outstanding_count_o = outst_q;
  assign play_index_o        = play_q;

endmodule

### rtl/abqd_checker.sv
`timescale 1ns / 1ps

module abqd_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [abqd_pkg::STATUS_W-1:0]      status_o,
  input logic                               completed_o,
  input logic                               dispatched_o,
  input logic [abqd_pkg::SLOT_W-1:0]        slot_index_o,
  input logic [abqd_pkg::ADDR_W-1:0]        source_address_o,
  input logic [abqd_pkg::COPY_W-1:0]        copy_bytes_o,
  input logic [abqd_pkg::START_W-1:0]       start_sample_o,
  input logic [abqd_pkg::END_W-1:0]         end_sample_o
);
  import abqd_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Zero the dispatch fields when nothing was dispatched
  a_no_disp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !dispatched_o |-> (slot_index_o == '0) && (source_address_o == '0)
      && (copy_bytes_o == '0) && (start_sample_o == '0) && (end_sample_o == '0))
    else $error("dispatch fields set without a dispatch");

  // Trim to whole frames and end at or after the start
  a_disp_frames: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dispatched_o |-> !copy_bytes_o[0]
      && (END_W'(start_sample_o) <= end_sample_o))
    else $error("dispatch not frame aligned");

  // Report a refused enqueue with no slot activity
  a_refused_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> !completed_o && !dispatched_o)
    else $error("refused enqueue shows slot activity");

endmodule

bind audio_buffer_queue_dispatcher abqd_checker u_abqd_checker (.*);

### tb/audio_buffer_queue_dispatcher_test.sv
`timescale 1ns / 1ps

module audio_buffer_queue_dispatcher_test;
  import abqd_pkg::*;

  localparam int FIFO_DEPTH = 16;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [REQ_W-1:0]      req;
    logic [ADDR_W-1:0]     addr;
    logic [LEN_W-1:0]      len;
    logic                  playing;
    logic [SLOT_COUNT-1:0] done_mask;
    logic                  accepts;
  } queue_request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                completed;
    logic                dispatched;
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   src;
    logic [COPY_W-1:0]   copy;
    logic [START_W-1:0]  start_sample;
    logic [END_W-1:0]    end_sample;
    logic [OUTST_W-1:0]  outstanding;
    logic [PLAY_W-1:0]   play_index;
  } dispatch_result_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [REQ_W-1:0]      req_type_i = REQ_TICK;
  logic [ADDR_W-1:0]     buffer_address_i = '0;
  logic [LEN_W-1:0]      buffer_length_i = '0;
  logic                  playing_i = 1'b0;
  logic [SLOT_COUNT-1:0] slot_done_mask_i = '0;
  logic                  downstream_accepts_i = 1'b0;

  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic                  completed_o;
  logic                  dispatched_o;
  logic [SLOT_W-1:0]     slot_index_o;
  logic [ADDR_W-1:0]     source_address_o;
  logic [COPY_W-1:0]     copy_bytes_o;
  logic [START_W-1:0]    start_sample_o;
  logic [END_W-1:0]      end_sample_o;
  logic [OUTST_W-1:0]    outstanding_count_o;
  logic [PLAY_W-1:0]     play_index_o;

  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_QUEUE_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  audio_buffer_queue_dispatcher #(
    .QUEUE_DEPTH(FIFO_DEPTH)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .req_type_i(req_type_i),
    .buffer_address_i(buffer_address_i),
    .buffer_length_i(buffer_length_i),
    .playing_i(playing_i),
    .slot_done_mask_i(slot_done_mask_i),
    .downstream_accepts_i(downstream_accepts_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o(status_o),
    .completed_o(completed_o),
    .dispatched_o(dispatched_o),
    .slot_index_o(slot_index_o),
    .source_address_o(source_address_o),
    .copy_bytes_o(copy_bytes_o),
    .start_sample_o(start_sample_o),
    .end_sample_o(end_sample_o),
    .outstanding_count_o(outstanding_count_o),
    .play_index_o(play_index_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  // Shadow copy of the descriptor queue, slots and registers
  logic [ADDR_W-1:0]     fifo_addr [FIFO_DEPTH];
  logic [LEN_W-1:0]      fifo_len [FIFO_DEPTH];
  int unsigned           rd_ptr;
  int unsigned           wr_ptr;
  int unsigned           fifo_count;
  logic [SLOT_COUNT-1:0] slot_busy;
  int unsigned           next_slot;
  logic [PLAY_W-1:0]     retired_total;
  logic [LIMIT_W-1:0]    limit_reg;
  logic [CHAN_W-1:0]     chan_reg;

  dispatch_result_t due_results[$];
  int mismatches = 0;
  int requests_sent = 0;
  int dispatch_total = 0;
  int retire_total = 0;
  int refused_total = 0;
  int clear_total = 0;
  int setting_total = 0;
  bit steady = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned busy_slots();
    int unsigned n;
    int i;
    n = 0;
    for (i = 0; i < SLOT_COUNT; i++) begin
      n += slot_busy[i];
    end
    return n;
  endfunction

  // Apply one request to the shadow state and return the result it causes
  function automatic dispatch_result_t advance_queue_state(queue_request_t rq);
    dispatch_result_t r;
    int unsigned lim;
    int unsigned idx;
    int unsigned searched;
    int unsigned bytes_per_frame;
    longint unsigned size;
    longint unsigned first;
    int i;
    r = '0;
    case (rq.req)
      REQ_ENQUEUE: begin
        lim = (limit_reg > FIFO_DEPTH) ? FIFO_DEPTH : limit_reg;
        if (rq.addr == '0 || rq.len == '0) begin
          r.status = ST_INVALID;
          refused_total++;
        end else if (fifo_count + busy_slots() >= lim) begin
          r.status = ST_FULL;
          refused_total++;
        end else begin
          fifo_addr[wr_ptr] = rq.addr;
          fifo_len[wr_ptr] = rq.len;
          wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
          fifo_count++;
          r.status = ST_OK;
        end
      end
      REQ_TICK: begin
        // Retire the lowest pending slot that reports done
        for (i = 0; i < SLOT_COUNT; i++) begin
          if (!r.completed && slot_busy[i] && rq.done_mask[i]) begin
            slot_busy[i] = 1'b0;
            retired_total++;
            r.completed = 1'b1;
            retire_total++;
          end
        end
        // Move the oldest buffer into the next free slot, round robin
        if (rq.playing && fifo_count > 0) begin
          idx = next_slot;
          searched = 0;
          while (searched < SLOT_COUNT && slot_busy[idx]) begin
            idx = (idx + 1) % SLOT_COUNT;
            searched++;
          end
          if (searched < SLOT_COUNT && rq.accepts) begin
            bytes_per_frame = (chan_reg == 0) ? 2 : ((chan_reg > 2) ? 4 : 2 * chan_reg);
            size = fifo_len[rd_ptr];
            if (size > BLOCK_BYTES) size = BLOCK_BYTES;
            size -= size % bytes_per_frame;
            first = (longint'(idx) * BLOCK_BYTES) / bytes_per_frame;
            r.dispatched = 1'b1;
            r.slot = idx[SLOT_W-1:0];
            r.src = fifo_addr[rd_ptr];
            r.copy = size[COPY_W-1:0];
            r.start_sample = first[START_W-1:0];
            r.end_sample = END_W'(first + size / bytes_per_frame);
            rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
            fifo_count--;
            slot_busy[idx] = 1'b1;
            next_slot = (idx + 1) % SLOT_COUNT;
            dispatch_total++;
          end
        end
      end
      REQ_CLEAR: begin
        rd_ptr = 0;
        wr_ptr = 0;
        fifo_count = 0;
        slot_busy = '0;
        clear_total++;
      end
      default: begin
      end
    endcase
    r.outstanding = OUTST_W'(fifo_count + busy_slots());
    r.play_index = retired_total;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] random_address();
    return ADDR_W'({$urandom(), $urandom()});
  endfunction

  function automatic queue_request_t make_enqueue(logic [ADDR_W-1:0] addr,
                                                  logic [LEN_W-1:0] len);
    queue_request_t rq;
    rq.req = REQ_ENQUEUE;
    rq.addr = addr;
    rq.len = len;
    rq.playing = 1'($urandom_range(1));
    rq.done_mask = SLOT_COUNT'($urandom_range(15));
    rq.accepts = 1'($urandom_range(1));
    return rq;
  endfunction

  function automatic queue_request_t make_tick(logic playing,
                                               logic [SLOT_COUNT-1:0] mask,
                                               logic accepts);
    queue_request_t rq;
    rq.req = REQ_TICK;
    rq.addr = random_address();
    rq.len = $urandom();
    rq.playing = playing;
    rq.done_mask = mask;
    rq.accepts = accepts;
    return rq;
  endfunction

  function automatic queue_request_t make_other(logic [REQ_W-1:0] req);
    queue_request_t rq;
    rq = make_tick(1'($urandom_range(1)), SLOT_COUNT'($urandom_range(15)),
                   1'($urandom_range(1)));
    rq.req = req;
    return rq;
  endfunction

  // Present one request and hold it until the block takes the transaction
  task automatic send_request(queue_request_t rq);
    int gap;
    gap = (!steady && $urandom_range(99) < 29) ? $urandom_range(4, 1) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= rq.req;
    buffer_address_i <= rq.addr;
    buffer_length_i <= rq.len;
    playing_i <= rq.playing;
    slot_done_mask_i <= rq.done_mask;
    downstream_accepts_i <= rq.accepts;
    do @(posedge clk_i); while (in_stall_o);
    due_results.push_back(advance_queue_state(rq));
    requests_sent++;
  endtask

  // Drop valid and hold off until every pending result has come back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_QUEUE_LIMIT) limit_reg = data[LIMIT_W-1:0];
    else chan_reg = data[CHAN_W-1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_setting(logic [CFG_DATA_W-1:0] limit, logic [CFG_DATA_W-1:0] chans);
    drain_results();
    write_register(CFG_QUEUE_LIMIT, limit);
    write_register(CFG_CHANNEL_COUNT, chans);
    setting_total++;
  endtask

  task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, field, want, got);
    end
  endtask

  // Compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin : result_checker
    dispatch_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        report_mismatch("unrequested result", 0, 1);
      end else begin
        want = due_results.pop_front();
        if (status_o !== want.status) report_mismatch("status", want.status, status_o);
        if (completed_o !== want.completed)
          report_mismatch("completed", want.completed, completed_o);
        if (dispatched_o !== want.dispatched)
          report_mismatch("dispatched", want.dispatched, dispatched_o);
        if (slot_index_o !== want.slot) report_mismatch("slot_index", want.slot, slot_index_o);
        if (source_address_o !== want.src)
          report_mismatch("source_address", want.src, source_address_o);
        if (copy_bytes_o !== want.copy) report_mismatch("copy_bytes", want.copy, copy_bytes_o);
        if (start_sample_o !== want.start_sample)
          report_mismatch("start_sample", want.start_sample, start_sample_o);
        if (end_sample_o !== want.end_sample)
          report_mismatch("end_sample", want.end_sample, end_sample_o);
        if (outstanding_count_o !== want.outstanding)
          report_mismatch("outstanding_count", want.outstanding, outstanding_count_o);
        if (play_index_o !== want.play_index)
          report_mismatch("play_index", want.play_index, play_index_o);
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 29);
  end

  task automatic test_argument_checks();
    send_request(make_enqueue('0, 100));
    send_request(make_enqueue(ADDR_MAX, '0));
    send_request(make_enqueue('0, '0));
    send_request(make_enqueue(ADDR_MAX, LEN_MAX));
  endtask

  // Walk the dispatch through all four slots, clamping and trimming on the way
  task automatic test_dispatch_paths();
    send_request(make_tick(1'b0, '0, 1'b1));
    send_request(make_tick(1'b1, '0, 1'b0));
    send_request(make_tick(1'b1, '0, 1'b1));
    send_request(make_enqueue(48'd1, 32'd7));
    send_request(make_tick(1'b1, '0, 1'b1));
    send_request(make_enqueue(48'h8000_0000_0000, 32'd3));
    send_request(make_tick(1'b1, '0, 1'b1));
    send_request(make_enqueue(48'h1234_5678_9ABC, 32'd65537));
    send_request(make_enqueue(48'h0F0F_0F0F_0F0F, 32'd10));
    send_request(make_tick(1'b1, '0, 1'b1));
    send_request(make_tick(1'b1, '0, 1'b1));
  endtask

  task automatic test_retire_order();
    send_request(make_tick(1'b1, 4'b1010, 1'b1));
    send_request(make_tick(1'b0, 4'b1111, 1'b0));
  endtask

  task automatic test_unknown_request();
    send_request(make_other(REQ_UNUSED));
  endtask

  // Clear, ignore done bits of idle slots, then refuse at the smallest limits
  task automatic test_clear_and_limits();
    send_request(make_other(REQ_CLEAR));
    send_request(make_tick(1'b1, 4'b1111, 1'b1));
    apply_setting(5'd1, 5'd2);
    send_request(make_enqueue(48'hABCD, 32'd4096));
    send_request(make_enqueue(48'hABCE, 32'd4096));
    apply_setting(5'd0, 5'd2);
    send_request(make_enqueue(48'hABCF, 32'd4096));
    send_request(make_enqueue(48'hABD0, '0));
    send_request(make_other(REQ_CLEAR));
  endtask

  function automatic queue_request_t random_request(int enq_pct);
    queue_request_t rq;
    logic [LEN_W-1:0] len;
    int pick;
    pick = $urandom_range(99);
    case ($urandom_range(2))
      0: len = $urandom_range(300, 1);
      1: len = $urandom_range(65540, 65530);
      default: len = $urandom();
    endcase
    if (len == '0) len = 1;
    if (pick < enq_pct) begin
      rq = make_enqueue(random_address() | 48'd1, len);
      // Break a few descriptors on purpose
      if ($urandom_range(19) == 0) begin
        if ($urandom_range(1)) rq.addr = '0;
        else rq.len = '0;
      end
    end else if (pick < 96) begin
      rq = make_tick($urandom_range(9) != 0,
                     $urandom_range(1) ? SLOT_COUNT'($urandom_range(15)) : '0,
                     $urandom_range(7) != 0);
    end else if (pick < 98) begin
      rq = make_other(REQ_CLEAR);
    end else begin
      rq = make_other(REQ_UNUSED);
    end
    return rq;
  endfunction

  task automatic run_traffic(logic [CFG_DATA_W-1:0] limit, logic [CFG_DATA_W-1:0] chans,
                             int enq_pct, int count, bit quiet);
    int i;
    apply_setting(limit, chans);
    steady = quiet;
    for (i = 0; i < count; i++) begin
      if (i == count / 2) drain_results();
      send_request(random_request(enq_pct));
    end
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_traffic(5'd16, 5'd2, 60, 150, 1'b0);
    run_traffic(5'd1, 5'd1, 50, 120, 1'b0);
    run_traffic(5'd0, 5'd3, 45, 60, 1'b0);
    run_traffic(5'd31, 5'd0, 65, 150, 1'b1);
    run_traffic(5'd4, 5'd6, 50, 150, 1'b0);
    run_traffic(5'd8, 5'd1, 55, 150, 1'b0);
    run_traffic(5'd2, 5'd2, 50, 120, 1'b0);
    run_traffic(5'd16, 5'd3, 55, 150, 1'b0);
  endtask

  initial begin
    rd_ptr = 0;
    wr_ptr = 0;
    fifo_count = 0;
    slot_busy = '0;
    next_slot = 0;
    retired_total = '0;
    limit_reg = LIMIT_RESET;
    chan_reg = CHAN_RESET;

    // Hold reset, then release it away from the sampling edge
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_argument_checks();
    test_dispatch_paths();
    test_retire_order();
    test_unknown_request();
    test_clear_and_limits();
    test_random_traffic();

    drain_results();
    repeat (10) @(posedge clk_i);
    if (due_results.size() != 0) mismatches++;

    $display("Sent %0d requests over %0d register settings: %0d dispatches, %0d retirements,",
             requests_sent, setting_total, dispatch_total, retire_total);
    $display("%0d refused enqueues, %0d clears; %0d mismatches.",
             refused_total, clear_total, mismatches);
    if (mismatches == 0) begin
      $display("audio_buffer_queue_dispatcher_test OK");
    end else begin
      $display("audio_buffer_queue_dispatcher_test NOT OK");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #3000000;
    $display("audio_buffer_queue_dispatcher_test NOT OK");
    $finish;
  end

endmodule
